// ----- rtl/ibfc_pkg.sv -----
// Shared types, constants and CRC table for the IMU burst frame checker.
package ibfc_pkg;

    localparam int FRAME_WORDS_DEF = 14;
    localparam int CRC_WORDS_DEF   = 11;

    localparam logic [15:0] DIAG_MASK_RESET = 16'h0020;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h1021;

    // Register map (byte addresses on the APB port)
    localparam int          PADDR_W           = 2;
    localparam logic [PADDR_W-1:0] ADDR_DIAG_FAIL_MASK = 2'd0;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic [3:0]  word_index;
        logic [15:0] word_value;
        logic        frame_end;
        logic        crc_ok;
        logic        diag_ok;
        logic [15:0] computed_crc;
    } ibfc_res_t;

    typedef logic [15:0] crc_tab_t [256];

    function automatic crc_tab_t build_crc_tab();
        crc_tab_t    tab;
        logic [15:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 16'(i);
            for (int r = 0; r < 8; r++) begin
                c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
            end
            tab[i] = c;
        end
        return tab;
    endfunction

    localparam crc_tab_t CRC_TAB = build_crc_tab();

    // One reflected byte step: (crc >> 8) ^ T[(crc ^ byte) & 0xFF]
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [7:0] idx;
        idx = c[7:0] ^ b;
        return {8'h00, c[15:8]} ^ CRC_TAB[idx];
    endfunction

endpackage

// ----- rtl/ibfc_crc_unit.sv -----
// CRC word step (low byte then high byte) and final inversion with byte swap.
module ibfc_crc_unit (
    input  logic [15:0] crc_in,
    input  logic [7:0]  high_byte,
    input  logic [7:0]  low_byte,
    output logic [15:0] crc_step,
    output logic [15:0] crc_final
);
    import ibfc_pkg::*;

    logic [15:0] crc_mid;
    logic [15:0] crc_inv;

    always_comb begin
        crc_mid   = crc_byte(crc_in, low_byte);
        crc_step  = crc_byte(crc_mid, high_byte);
        crc_inv   = ~crc_in;
        crc_final = {crc_inv[7:0], crc_inv[15:8]};
    end

endmodule

// ----- rtl/ibfc_frame_core.sv -----
// Frame tracking state: byte position, held byte, running CRC, diagnostic word.
module ibfc_frame_core #(
    parameter int FRAME_WORDS = ibfc_pkg::FRAME_WORDS_DEF,
    parameter int CRC_WORDS   = ibfc_pkg::CRC_WORDS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat_accept,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    input  logic [15:0]        diag_fail_mask,
    output logic               res_valid,
    output ibfc_pkg::ibfc_res_t res
);
    import ibfc_pkg::*;

    localparam int POS_W  = $clog2(2 * FRAME_WORDS + 1);
    localparam int WIDX_W = POS_W - 1;

    logic [POS_W-1:0]  pos_reg, pos_next, pos_eff;
    logic [7:0]        held_reg, held_next;
    logic [15:0]       crc_reg, crc_next, crc_eff;
    logic [15:0]       diag_reg, diag_next, diag_eff;
    logic [WIDX_W-1:0] widx;
    logic [15:0]       word;
    logic              active, odd, is_last, in_window;
    logic [15:0]       crc_step, crc_final;

    ibfc_crc_unit u_crc (
        .crc_in    (crc_eff),
        .high_byte (held_reg),
        .low_byte  (rx_byte),
        .crc_step  (crc_step),
        .crc_final (crc_final)
    );

    always_comb begin
        pos_eff  = frame_start ? '0 : pos_reg;
        crc_eff  = frame_start ? CRC_INIT : crc_reg;
        diag_eff = frame_start ? 16'h0000 : diag_reg;

        active    = pos_eff < POS_W'(2 * FRAME_WORDS);
        odd       = pos_eff[0];
        widx      = pos_eff[POS_W-1:1];
        word      = {held_reg, rx_byte};
        is_last   = widx == WIDX_W'(FRAME_WORDS - 1);
        in_window = (32'(widx) >= 32'd2) && (32'(widx) < 32'(2 + CRC_WORDS));

        res_valid = active && odd && (widx != '0);

        res              = '0;
        res.word_index   = 4'(widx);
        res.word_value   = word;
        if (is_last) begin
            res.frame_end    = 1'b1;
            res.crc_ok       = word == crc_final;
            res.diag_ok      = (diag_eff & diag_fail_mask) == 16'h0000;
            res.computed_crc = crc_final;
        end

        pos_next  = pos_reg;
        held_next = held_reg;
        crc_next  = crc_reg;
        diag_next = diag_reg;
        if (beat_accept) begin
            pos_next  = pos_eff;
            crc_next  = crc_eff;
            diag_next = diag_eff;
            if (active) begin
                pos_next = pos_eff + POS_W'(1);
                if (!odd) begin
                    held_next = rx_byte;
                end else if (!is_last) begin
                    if (widx == WIDX_W'(1)) begin
                        diag_next = word;
                    end
                    if (in_window) begin
                        crc_next = crc_step;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            held_reg <= 8'h00;
            crc_reg  <= CRC_INIT;
            diag_reg <= 16'h0000;
        end else begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
            crc_reg  <= crc_next;
            diag_reg <= diag_next;
        end
    end

endmodule

// ----- rtl/imu_burst_frame_checker_unit.sv -----
// Top level of the IMU burst frame checker: APB register, frame core, output register.
//
// Usage:
//   Input stream (s_*): one received burst byte per beat, most significant byte of
//   each 16-bit word first. s_tdata[7:0] carries the byte; s_tuser flags byte 0 of
//   a new frame and clears position, CRC and diagnostic word before that byte.
//   Output stream (m_*): one beat per completed word from index 1 to the last word.
//   m_tlast marks the CRC word, the last beat of a frame, which also carries the
//   verdict (crc_ok, diag_ok) and the computed CRC; on other beats these are zero.
//   Word 0 and bytes beyond the frame produce no beat.
//   APB port: register diag_fail_mask at byte address 0 (reset 0x0020); a set
//   diagnostic bit under the mask fails the frame. Write only while idle.
// Timing:
//   One byte per cycle sustained while m_tready does not stall a held result; the CRC
//   word step (two chained table lookups) feeds back into the running CRC register.
//   A result appears on m_* in the cycle after the byte that completes its word is accepted.
// Reset (aresetn low, synchronous): position 0, CRC 0xFFFF, output stream empty.
// Stall: while m_tready is low a held result blocks every input byte; s_tready
//   stays high whenever the output register is empty or being emptied.
module imu_burst_frame_checker_unit #(
    parameter int FRAME_WORDS = ibfc_pkg::FRAME_WORDS_DEF,
    parameter int CRC_WORDS   = ibfc_pkg::CRC_WORDS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ibfc_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ibfc_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] rx_byte
    input  logic                             s_tuser,  // [0] frame_start
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ibfc_pkg::M_TDATA_W-1:0]   m_tdata,  // [3:0] word_index, [19:4] word_value,
                                                       // [20] crc_ok, [21] diag_ok,
                                                       // [37:22] computed_crc, [39:38] zero
    output logic                             m_tlast   // frame_end
);
    import ibfc_pkg::*;

    logic        s_accept;
    logic        res_valid;
    ibfc_res_t   res;
    logic [15:0] mask_reg, mask_next;
    logic        m_valid_reg, m_valid_next;
    ibfc_res_t   m_res_reg, m_res_next;

    // Configuration register: write on the access phase
    always_comb begin
        pready    = 1'b1;
        mask_next = mask_reg;
        if (psel && penable && pwrite && pready && (paddr == ADDR_DIAG_FAIL_MASK)) begin
            mask_next = pwdata[15:0];
        end
        prdata = (paddr == ADDR_DIAG_FAIL_MASK) ? {16'h0000, mask_reg} : 32'h0000_0000;
    end

    // Take a new byte whenever the output register is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    ibfc_frame_core #(
        .FRAME_WORDS (FRAME_WORDS),
        .CRC_WORDS   (CRC_WORDS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .beat_accept    (s_accept),
        .rx_byte        (s_tdata[7:0]),
        .frame_start    (s_tuser),
        .diag_fail_mask (mask_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Output register: load a new result, else drop the one just taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (s_accept && res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= DIAG_MASK_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_res_reg.frame_end;
    assign m_tdata  = {2'b00, m_res_reg.computed_crc, m_res_reg.diag_ok, m_res_reg.crc_ok,
                       m_res_reg.word_value, m_res_reg.word_index};

endmodule

// ----- rtl/ibfc_checker.sv -----
// Port-level assertions for the IMU burst frame checker, bound to the top level.
module ibfc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ibfc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import ibfc_pkg::*;

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Verdict fields stay zero off the last word
    a_verdict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[37:20] == 18'd0)
        else $error("verdict fields set on a non-final word");

    // crc_ok agrees with the received word against the computed CRC
    a_crc_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[20] == (m_tdata[19:4] == m_tdata[37:22]))
        else $error("crc_ok disagrees with word and computed CRC");

    // An empty output register never holds off the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with the output register empty");

    // Output empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind imu_burst_frame_checker_unit ibfc_checker u_ibfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
